// ===== rtl/vqtt_pkg.sv =====
// ----------------------------------------------------------------------------
// vqtt_pkg
// Shared types and constants of the VQ twiddled texture decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vqtt_pkg;

  localparam int CODEBOOK_DEPTH_DEF = 1024;
  localparam int MAX_SIDE_DEF       = 4096;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CODEBOOK_ENTRIES = 2'd0,
    REG_SMALL_MODE       = 2'd1,
    REG_IMAGE_WIDTH      = 2'd2,
    REG_CODE_BYTE_COUNT  = 2'd3
  } reg_index_t;

  localparam int CFG_DATA_W = 23;

  localparam logic [10:0] ENTRIES_RST = 11'd1024;
  localparam logic [12:0] WIDTH_RST   = 13'd4096;
  localparam logic [22:0] COUNT_RST   = 23'd4194304;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [9:0]  entry_address;
    logic [15:0] entry_value;
    logic [21:0] code_offset;
    logic [7:0]  code_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] pixel_value;
    logic        error;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [10:0] codebook_entries;
    logic        small_mode;
    logic [12:0] image_width;
    logic [22:0] code_byte_count;
  } cfg_t;

  // Block position and verdict of one decode request.
  typedef struct packed {
    logic        bad;
    logic [10:0] bx;
    logic [10:0] by;
  } decode_info_t;

endpackage

`default_nettype wire

// ===== rtl/vqtt_ram.sv =====
// ----------------------------------------------------------------------------
// vqtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vqtt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = vqtt_pkg::CODEBOOK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vqtt_check.sv =====
// ----------------------------------------------------------------------------
// vqtt_check
// De-interleaves the code offset and checks a decode request against bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module vqtt_check #(
  parameter int CODEBOOK_DEPTH = vqtt_pkg::CODEBOOK_DEPTH_DEF,
  parameter int MAX_SIDE       = vqtt_pkg::MAX_SIDE_DEF
) (
  input  vqtt_pkg::cfg_t         cfg,
  input  logic [21:0]            code_offset,
  input  logic [7:0]             code_byte,
  output vqtt_pkg::decode_info_t info
);

  logic [10:0] bx;
  logic [10:0] by;
  logic [12:0] side;
  logic [9:0]  base;
  logic        bad_offset;
  logic        bad_grid;
  logic        bad_small;
  logic        bad_depth;

  // Odd offset bits form the block column, even bits the block row.
  always_comb begin
    for (int i = 0; i < 11; i++) begin
      bx[i] = code_offset[2*i+1];
      by[i] = code_offset[2*i];
    end
  end

  assign side = (cfg.image_width > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : cfg.image_width;
  assign base = {code_byte, 2'b00};

  assign bad_offset = {1'b0, code_offset} >= cfg.code_byte_count;
  assign bad_grid   = ({1'b0, bx, 1'b0} + 13'd2 > side) ||
                      ({1'b0, by, 1'b0} + 13'd2 > side);
  assign bad_small  = cfg.small_mode && ({1'b0, base} + 11'd4 > cfg.codebook_entries);
  assign bad_depth  = {2'b00, base} + 12'd3 >= 12'(CODEBOOK_DEPTH);

  assign info.bad = bad_offset || bad_grid || bad_small || bad_depth;
  assign info.bx  = bx;
  assign info.by  = by;

endmodule

`default_nettype wire

// ===== rtl/vq_twiddled_texture_decoder.sv =====
// ----------------------------------------------------------------------------
// vq_twiddled_texture_decoder
// Loads a VQ codebook and expands twiddled code bytes into 2x2 pixel blocks.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  item     | in        | item_valid / item_stall  | vqtt_pkg::in_item_t
//  pixel    | out       | pixel_valid / pixel_stall| vqtt_pkg::out_item_t
//  cfg      | in        | cfg_we                   | cfg_index, cfg_data
//
// A load request writes one codebook entry; a decode request makes one
// codebook read per pixel through the single read port, or gives a single
// error result with no read. Read data is registered in the read stage,
// then in the pixel output register. Reset is synchronous and clears
// control state and configuration; the codebook holds no reset value. A
// stalled pixel output back-pressures the read pipeline, then the item channel.
// ----------------------------------------------------------------------------
`default_nettype none

module vq_twiddled_texture_decoder #(
  parameter int CODEBOOK_DEPTH = vqtt_pkg::CODEBOOK_DEPTH_DEF,
  parameter int MAX_SIDE       = vqtt_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  vqtt_pkg::in_item_t              item,
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output vqtt_pkg::out_item_t             pixel,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [vqtt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(CODEBOOK_DEPTH);

  vqtt_pkg::cfg_t         cfg;
  vqtt_pkg::decode_info_t info_next;

  // Request register.
  logic                   req_valid;
  vqtt_pkg::in_item_t     req;
  vqtt_pkg::decode_info_t req_info;
  logic [1:0]             beat;

  // Read stage.
  logic        s1_valid;
  logic [11:0] s1_x;
  logic [11:0] s1_y;
  logic        s1_err;
  logic        s1_last;
  logic [15:0] rd_data;

  logic accept;
  logic s1_ready;
  logic s2_ready;
  logic issue;
  logic load_wr;
  logic done;
  logic rd_en;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.codebook_entries <= vqtt_pkg::ENTRIES_RST;
      cfg.small_mode       <= 1'b0;
      cfg.image_width      <= vqtt_pkg::WIDTH_RST;
      cfg.code_byte_count  <= vqtt_pkg::COUNT_RST;
    end else if (cfg_we) begin
      case (vqtt_pkg::reg_index_t'(cfg_index))
        vqtt_pkg::REG_CODEBOOK_ENTRIES: cfg.codebook_entries <= cfg_data[10:0];
        vqtt_pkg::REG_SMALL_MODE:       cfg.small_mode       <= cfg_data[0];
        vqtt_pkg::REG_IMAGE_WIDTH:      cfg.image_width      <= cfg_data[12:0];
        vqtt_pkg::REG_CODE_BYTE_COUNT:  cfg.code_byte_count  <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  vqtt_check #(
    .CODEBOOK_DEPTH (CODEBOOK_DEPTH),
    .MAX_SIDE       (MAX_SIDE)
  ) u_check (
    .cfg         (cfg),
    .code_offset (item.code_offset),
    .code_byte   (item.code_byte),
    .info        (info_next)
  );

  assign s2_ready = !pixel_valid || !pixel_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign load_wr  = req_valid && (req.opcode == vqtt_pkg::OP_LOAD);
  assign issue    = req_valid && (req.opcode == vqtt_pkg::OP_DECODE) && s1_ready;
  assign done     = load_wr || (issue && (req_info.bad || beat == 2'd3));
  assign item_stall = req_valid && !done;
  assign accept     = item_valid && !item_stall;

  assign rd_en = issue && !req_info.bad;
  assign wr_en = load_wr && ({1'b0, req.entry_address} < 11'(CODEBOOK_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      beat      <= 2'd0;
    end else begin
      if (accept) begin
        req_valid <= 1'b1;
      end else if (done) begin
        req_valid <= 1'b0;
      end
      if (done) begin
        beat <= 2'd0;
      end else if (issue) begin
        beat <= beat + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= item;
      req_info <= info_next;
    end
  end

  vqtt_ram #(
    .WIDTH (16),
    .DEPTH (CODEBOOK_DEPTH)
  ) u_codebook (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (req.entry_address[AW-1:0]),
    .wr_data (req.entry_value),
    .rd_en   (rd_en),
    .rd_addr (AW'({req.code_byte, beat})),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= issue;
    end
  end

  // Pixel order within the block follows the beat: column bit is beat[1].
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_x    <= {req_info.bx, beat[1]};
      s1_y    <= {req_info.by, beat[0]};
      s1_err  <= req_info.bad;
      s1_last <= req_info.bad || (beat == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (s2_ready) begin
      pixel_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      pixel.pixel_x     <= s1_err ? 12'd0 : s1_x;
      pixel.pixel_y     <= s1_err ? 12'd0 : s1_y;
      pixel.pixel_value <= s1_err ? 16'd0 : rd_data;
      pixel.error       <= s1_err;
      pixel.last        <= s1_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.error |-> pixel.last)
    else $error("error result without last mark");

  a_stall_needs_req: assert property (@(posedge clk) disable iff (rst)
    !req_valid |-> !item_stall)
    else $error("item channel stalled with no request held");

  a_beat_in_decode: assert property (@(posedge clk) disable iff (rst)
    beat != 2'd0 |-> req_valid && req.opcode == vqtt_pkg::OP_DECODE && !req_info.bad)
    else $error("beat counter running outside a good decode");

  a_issue_fills_s1: assert property (@(posedge clk) disable iff (rst)
    issue |=> s1_valid)
    else $error("issued read did not reach the read stage");
`endif

endmodule

`default_nettype wire
